// File: rtl/xrg_pkg.sv
`timescale 1ns / 1ps
package xrg_pkg;

	// field widths
	localparam int unsigned STATE_W = 64;
	localparam int unsigned INT_W   = 32;
	localparam int unsigned SPAN_W  = INT_W + 1;
	localparam int unsigned OP_W    = 2;

	// remainder unit bit counter
	localparam int unsigned DIV_CNT_W = $clog2(STATE_W);

	// xorshift shift amounts
	localparam int unsigned SHIFT_A = 13;
	localparam int unsigned SHIFT_B = 7;
	localparam int unsigned SHIFT_C = 17;

	// fraction output shifts: 24-bit and 53-bit fractions
	localparam int unsigned FRAC24_SHIFT = STATE_W - 24;
	localparam int unsigned FRAC53_SHIFT = STATE_W - 53;

	localparam logic [STATE_W-1:0] STATE_ONE = STATE_W'(1);
	localparam logic [STATE_W-1:0] STATE_MAX = '1;

	// request opcodes
	localparam logic [OP_W-1:0] OP_RAW    = 2'd0;
	localparam logic [OP_W-1:0] OP_RANGE  = 2'd1;
	localparam logic [OP_W-1:0] OP_FRAC24 = 2'd2;
	localparam logic [OP_W-1:0] OP_FRAC53 = 2'd3;

	// remainder unit request and response
	typedef struct packed {
		logic               start;
		logic [STATE_W-1:0] dividend;
		logic [SPAN_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SPAN_W-1:0] remainder;
	} div_rsp_t;

	// one xorshift step
	function automatic logic [STATE_W-1:0] xs_next(input logic [STATE_W-1:0] s);
		logic [STATE_W-1:0] t;
		t = s ^ (s << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		t = t ^ (t << SHIFT_C);
		return t;
	endfunction

endpackage

// File: rtl/xrg_req_if.sv
`timescale 1ns / 1ps
interface xrg_req_if;
	logic                                valid;
	logic                                ready;
	logic [xrg_pkg::OP_W-1:0]            opcode;
	logic signed [xrg_pkg::INT_W-1:0]    range_min;
	logic signed [xrg_pkg::INT_W-1:0]    range_max;

	modport source (output valid, output opcode, output range_min, output range_max,
		input ready);
	modport sink (input valid, input opcode, input range_min, input range_max,
		output ready);
endinterface

// File: rtl/xrg_rsp_if.sv
`timescale 1ns / 1ps
interface xrg_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [xrg_pkg::INT_W-1:0]   int_value;
	logic [xrg_pkg::STATE_W-1:0]        bits_value;
	logic                               bad_range;

	modport source (output valid, output int_value, output bits_value, output bad_range,
		input ready);
	modport sink (input valid, input int_value, input bits_value, input bad_range,
		output ready);
endinterface

// File: rtl/xorshift64_range_generator.sv
`timescale 1ns / 1ps
// 64-bit xorshift generator (shifts 13, 7, 17) serving one request per transaction.
// req carries opcode, range_min and range_max; rsp returns int_value, bits_value
// and bad_range. Both are valid/ready channels; a transaction completes when
// valid and ready are high at a rising edge. seed_we with seed_wdata reloads the
// state (zero loads one); write it only while no request is in flight.
// Raw and fraction requests, and a ranged request with min above max, pass from
// acceptance to the finish state and are loaded into the output register when it
// is free. A ranged request runs the serial remainder unit twice (once for the
// rejection limit, once to reduce the accepted draw), with draws tried between, and
// each rejected draw is followed by another. The remainder unit takes one dividend bit per cycle.
// The block takes one request at a time; req.ready is high while idle, even if
// a finished result still waits in the output register. If the receiver stalls,
// the result holds and the next finished result waits until it is taken.
// arst_n clears the handshakes and loads a state of one.
module xorshift64_range_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	xrg_req_if.sink                      req,
	xrg_rsp_if.source                    rsp,
	input  logic                         seed_we,
	input  logic [xrg_pkg::STATE_W-1:0]  seed_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_DRAW,
		ST_REDUCE,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [xrg_pkg::STATE_W-1:0]     gen_q;
	logic [xrg_pkg::STATE_W-1:0]     limit_q;
	logic [xrg_pkg::SPAN_W-1:0]      span_q;
	logic [xrg_pkg::INT_W-1:0]       lo_q;
	logic [xrg_pkg::INT_W-1:0]       int_q;
	logic [xrg_pkg::STATE_W-1:0]     bits_q;
	logic                            bad_q;
	logic                            out_valid_q;
	logic [xrg_pkg::INT_W-1:0]       out_int_q;
	logic [xrg_pkg::STATE_W-1:0]     out_bits_q;
	logic                            out_bad_q;

	logic [xrg_pkg::STATE_W-1:0]     gen_nxt;
	logic                            req_fire;
	logic                            in_bad;
	logic [xrg_pkg::SPAN_W-1:0]      in_span;
	logic                            draw_ok;
	logic                            out_free;
	xrg_pkg::div_req_t               div_req;
	xrg_pkg::div_rsp_t               div_rsp;

	// next state and request decode
	always_comb begin
		gen_nxt  = xrg_pkg::xs_next(gen_q);
		req_fire = req.valid && (state_q == ST_IDLE);
		in_bad   = (req.range_min > req.range_max);
		in_span  = {req.range_max[xrg_pkg::INT_W-1], req.range_max}
			- {req.range_min[xrg_pkg::INT_W-1], req.range_min} + xrg_pkg::SPAN_W'(1);
		draw_ok  = (gen_nxt < limit_q);
		out_free = !out_valid_q || rsp.ready;
	end

	// remainder unit requests: limit first, then reduction of the accepted draw
	always_comb begin
		div_req = '0;
		if (req_fire && req.opcode == xrg_pkg::OP_RANGE && !in_bad) begin
			div_req.start    = 1'b1;
			div_req.dividend = xrg_pkg::STATE_MAX;
			div_req.divisor  = in_span;
		end else if (state_q == ST_DRAW && draw_ok) begin
			div_req.start    = 1'b1;
			div_req.dividend = gen_nxt;
			div_req.divisor  = span_q;
		end
	end

	xrg_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, generator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= xrg_pkg::STATE_ONE;
			limit_q     <= '0;
			span_q      <= '0;
			lo_q        <= '0;
			int_q       <= '0;
			bits_q      <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_int_q   <= '0;
			out_bits_q  <= '0;
			out_bad_q   <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (seed_we) begin
				gen_q <= (seed_wdata == '0) ? xrg_pkg::STATE_ONE : seed_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						int_q  <= '0;
						bits_q <= '0;
						bad_q  <= 1'b0;
						lo_q   <= req.range_min;
						span_q <= in_span;
						state_q <= ST_FINISH;
						case (req.opcode)
							xrg_pkg::OP_RAW: begin
								gen_q  <= gen_nxt;
								bits_q <= gen_nxt;
							end
							xrg_pkg::OP_RANGE: begin
								if (in_bad) begin
									bad_q <= 1'b1;
								end else begin
									state_q <= ST_LIMIT;
								end
							end
							xrg_pkg::OP_FRAC24: begin
								gen_q  <= gen_nxt;
								bits_q <= gen_nxt >> xrg_pkg::FRAC24_SHIFT;
							end
							default: begin
								gen_q  <= gen_nxt;
								bits_q <= gen_nxt >> xrg_pkg::FRAC53_SHIFT;
							end
						endcase
					end
				end
				ST_LIMIT: begin
					if (div_rsp.done) begin
						limit_q <= xrg_pkg::STATE_MAX
							- {{(xrg_pkg::STATE_W - xrg_pkg::SPAN_W){1'b0}}, div_rsp.remainder};
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					// one draw per cycle, rejected draws fall through to the next
					gen_q <= gen_nxt;
					if (draw_ok) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (div_rsp.done) begin
						int_q   <= lo_q + div_rsp.remainder[xrg_pkg::INT_W-1:0];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_int_q   <= int_q;
						out_bits_q  <= bits_q;
						out_bad_q   <= bad_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.int_value  = out_int_q;
	assign rsp.bits_value = out_bits_q;
	assign rsp.bad_range  = out_bad_q;

endmodule

// File: rtl/xrg_divider.sv
`timescale 1ns / 1ps
// bit-serial restoring remainder unit, one dividend bit per cycle
module xrg_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  xrg_pkg::div_req_t  req,
	output xrg_pkg::div_rsp_t  rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [xrg_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [xrg_pkg::STATE_W-1:0]     dvd_q;
	logic [xrg_pkg::SPAN_W-1:0]      dvs_q;
	logic [xrg_pkg::SPAN_W-1:0]      rem_q;

	logic [xrg_pkg::SPAN_W:0]        rem_sh;
	logic [xrg_pkg::SPAN_W:0]        rem_diff;
	logic [xrg_pkg::SPAN_W-1:0]      rem_nxt;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		rem_sh   = {rem_q, dvd_q[xrg_pkg::STATE_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		if (rem_sh >= {1'b0, dvs_q}) begin
			rem_nxt = rem_diff[xrg_pkg::SPAN_W-1:0];
		end else begin
			rem_nxt = rem_sh[xrg_pkg::SPAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule
